FILE: hw/rtl/tds_pkg.sv
// tds_pkg: types and constants shared by the tridiagonal solver modules.
// Depends on nothing.
package tds_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV1,
    ST_DIV1_WAIT,
    ST_DIV2,
    ST_DIV2_WAIT,
    ST_STORE,
    ST_BACK_RD,
    ST_BACK_MUL,
    ST_BACK_ADD,
    ST_EMIT
  } tds_state_t;

  // Row index width on the output channel
  localparam int ROW_W = 6;

  // One row of the system on the input channel
  typedef struct packed {
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs;
    logic               last_row;
  } row_t;

  // One unknown on the output channel
  typedef struct packed {
    logic signed [31:0] solution;
    logic [ROW_W-1:0]   row_index;
    logic               last_result;
    logic               singular;
  } soln_t;

endpackage

FILE: hw/rtl/tds_if.sv
// tds_if: valid/ready channel carrying one payload struct.
// Depends on nothing; payload type is a parameter.
interface tds_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tds_div.sv
// tds_div: iterative signed fixed-point divider, one quotient bit a cycle.
// Depends on tds_pkg. Result is (n << FRAC_BITS) / d, truncated and saturated.
module tds_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic signed [DATA_WIDTH-1:0] den,
  output logic                         done,
  output logic                         zero_den,
  output logic signed [DATA_WIDTH-1:0] quot
);
  import tds_pkg::*;
  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic [NW-1:0] LIM = NW'(1) << (DATA_WIDTH - 1);

  logic [NW-1:0]         dividend;
  logic [NW-1:0]         q;
  logic [DATA_WIDTH:0]   rem;
  logic [DATA_WIDTH-1:0] dmag;
  logic [CW-1:0]         count;
  logic                  neg;
  logic                  busy;
  logic                  zd;
  logic signed [DATA_WIDTH-1:0] zq;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH-1:0] nmag;

  assign nmag = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : DATA_WIDTH'(num);
  assign rem_sh = {rem[DATA_WIDTH-1:0], dividend[NW-1]};

  // one restoring step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg      <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
        dmag     <= den[DATA_WIDTH-1] ? DATA_WIDTH'(-den) : DATA_WIDTH'(den);
        dividend <= {nmag, FRAC_BITS'(0)};
        rem      <= '0;
        q        <= '0;
        zd       <= (den == '0);
        zq       <= (num == '0) ? '0 :
                    num[DATA_WIDTH-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                      : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        count    <= CW'(NW);
        busy     <= (den != '0);
        done     <= (den == '0);
      end else if (busy) begin
        dividend <= dividend << 1;
        if (rem_sh >= {1'b0, dmag}) begin
          rem <= rem_sh - {1'b0, dmag};
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q   <= {q[NW-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate magnitude to signed range
  always_comb begin
    zero_den = zd;
    if (zd) quot = zq;
    else if (neg) quot = (q >= LIM) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                    : DATA_WIDTH'(-q);
    else quot = (q >= LIM) ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : DATA_WIDTH'(q);
  end
endmodule

FILE: hw/rtl/tds_store.sv
// tds_store: per-row ratio and offset memory, one write and one read port.
// Depends on tds_pkg. Read data is registered.
module tds_store #(
  parameter int DATA_WIDTH = 32,
  parameter int MAX_ROWS = 64
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_ROWS)-1:0]    wr_addr,
  input  logic [2*DATA_WIDTH-1:0]        wr_data,
  input  logic [$clog2(MAX_ROWS)-1:0]    rd_addr,
  output logic [2*DATA_WIDTH-1:0]        rd_data
);
  import tds_pkg::*;
  logic [2*DATA_WIDTH-1:0] mem [MAX_ROWS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hw/rtl/tridiagonal_system_solver_top.sv
// Tridiagonal solver top: Thomas algorithm, Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS.
// Non-last row: two serial divides (ratio, then offset).
// Last row: one divide, then a store read, multiply and add per further result.
// Synchronous active-high reset clears control; the row store holds no reset.
module tridiagonal_system_solver_top #(
  parameter int MAX_ROWS = 64,
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  tds_if.sink   in_ch,
  tds_if.source out_ch
);
  import tds_pkg::*;
  localparam int AW = $clog2(MAX_ROWS);
  localparam int PW = 2 * DATA_WIDTH;
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  tds_state_t state, state_next;
  logic [AW-1:0] row_count, k, bi;
  logic signed [DATA_WIDTH-1:0] prev_ratio, prev_offset;
  logic singular_seen;
  logic signed [DATA_WIDTH-1:0] ra, rb, rc, rd, den, numr, x, ratio_new, prod;
  logic is_last;
  logic signed [PW-1:0] mul_a, mul_b, mul_p;
  logic div_start, div_done, div_zero;
  logic signed [DATA_WIDTH-1:0] div_n, div_d, div_q;
  logic st_wr;
  logic [PW-1:0] st_rd;
  logic [AW-1:0] st_raddr;

  function automatic logic signed [DATA_WIDTH-1:0] sat_w(
      input logic signed [DATA_WIDTH+1:0] v);
    if (v > (DATA_WIDTH+2)'(MAXV)) return MAXV;
    if (v < (DATA_WIDTH+2)'(MINV)) return MINV;
    return DATA_WIDTH'(v);
  endfunction

  // product: truncate toward zero then saturate
  function automatic logic signed [DATA_WIDTH-1:0] fx_sat(
      input logic signed [PW-1:0] p);
    logic [PW-1:0] m;
    logic [PW-1:0] s;
    m = p[PW-1] ? PW'(-p) : PW'(p);
    s = m >> FRAC_BITS;
    if (p[PW-1]) return (s >= PW'(MINV[DATA_WIDTH-1:0])) ? MINV
                        : DATA_WIDTH'(-s);
    return (s > PW'(MAXV)) ? MAXV : DATA_WIDTH'(s);
  endfunction

  assign mul_p = mul_a * mul_b;

  tds_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .zero_den(div_zero), .quot(div_q));

  tds_store #(.DATA_WIDTH(DATA_WIDTH), .MAX_ROWS(MAX_ROWS)) u_store (
    .clk, .wr_en(st_wr), .wr_addr(k), .wr_data({ratio_new, div_q}),
    .rd_addr(st_raddr), .rd_data(st_rd));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_ch.valid) state_next = ST_MUL1;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = is_last ? ST_DIV2 : ST_DIV1;
      ST_DIV1:      state_next = ST_DIV1_WAIT;
      ST_DIV1_WAIT: if (div_done) state_next = ST_DIV2;
      ST_DIV2:      state_next = ST_DIV2_WAIT;
      ST_DIV2_WAIT: if (div_done) state_next = is_last ? ST_EMIT : ST_STORE;
      ST_STORE:     state_next = ST_IDLE;
      ST_EMIT:      if (out_ch.ready) state_next = (bi == '0) ? ST_IDLE : ST_BACK_RD;
      ST_BACK_RD:   state_next = ST_BACK_MUL;
      ST_BACK_MUL:  state_next = ST_BACK_ADD;
      ST_BACK_ADD:  state_next = ST_EMIT;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    div_start = (state == ST_DIV1) || (state == ST_DIV2);
    div_n = (state == ST_DIV1) ? sat_w(-(DATA_WIDTH+2)'(rc)) : numr;
    div_d = den;
    st_wr = (state == ST_STORE);
    // bi already points at the row being back-substituted
    st_raddr = bi;
    mul_a = PW'(ra);
    mul_b = PW'(prev_ratio);
    if (state == ST_MUL2) mul_b = PW'(prev_offset);
    if (state == ST_BACK_MUL) begin
      mul_a = PW'($signed(st_rd[PW-1:DATA_WIDTH]));
      mul_b = PW'(x);
    end
    out_ch.valid = (state == ST_EMIT);
    out_ch.data.solution = x;
    out_ch.data.row_index = ROW_W'(bi);
    out_ch.data.last_result = (bi == '0);
    out_ch.data.singular = singular_seen;
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row_count <= '0;
      prev_ratio <= '0;
      prev_offset <= '0;
      singular_seen <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          k  <= row_count;
          ra <= (row_count == '0) ? '0 : in_ch.data.sub_diag;
          rb <= in_ch.data.main_diag;
          rc <= in_ch.data.super_diag;
          rd <= in_ch.data.rhs;
          is_last <= in_ch.data.last_row || (row_count == AW'(MAX_ROWS - 1));
        end
        ST_MUL1: den <= sat_w((DATA_WIDTH+2)'(fx_sat(mul_p)) + (DATA_WIDTH+2)'(rb));
        ST_MUL2: numr <= sat_w((DATA_WIDTH+2)'(rd) - (DATA_WIDTH+2)'(fx_sat(mul_p)));
        ST_DIV1_WAIT: if (div_done) begin
          ratio_new <= div_q;
          if (div_zero) singular_seen <= 1'b1;
        end
        ST_DIV2_WAIT: if (div_done) begin
          if (div_zero) singular_seen <= 1'b1;
          x  <= div_q;
          bi <= k;
        end
        ST_STORE: begin
          prev_ratio <= ratio_new;
          prev_offset <= div_q;
          row_count <= k + AW'(1);
        end
        ST_EMIT: if (out_ch.ready) begin
          bi <= bi - AW'(1);
          if (bi == '0) begin
            row_count <= '0;
            prev_ratio <= '0;
            prev_offset <= '0;
            singular_seen <= 1'b0;
          end
        end
        ST_BACK_MUL: prod <= fx_sat(mul_p);
        ST_BACK_ADD: x <= sat_w((DATA_WIDTH+2)'(prod)
                          + (DATA_WIDTH+2)'($signed(st_rd[DATA_WIDTH-1:0])));
        default: ;
      endcase
    end
  end
endmodule

FILE: hw/rtl/tds_checker.sv
// tds_checker: port-level assertions for the solver top level.
// Depends on tds_pkg; bound to tridiagonal_system_solver_top.
module tds_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [5:0] out_row,
  input logic out_last
);
  import tds_pkg::*;

  // a taken request closes the input for the next cycle
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("input still open");
  // no request is taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during output");
  // end flag marks row zero
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_row == 6'd0))) else $error("bad end flag");
  // stalled result holds its row
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row)) else $error("drop");
  // rows descend by one
  a_desc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> ##3 out_valid
      && (out_row == $past(out_row, 4) - 6'd1))
    else $error("row order");
endmodule

bind tridiagonal_system_solver_top tds_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_row(out_ch.data.row_index), .out_last(out_ch.data.last_result));

FILE: dv/tridiagonal_system_solver_top_tb.sv
// Testbench for tridiagonal_system_solver_top: streams rows of tridiagonal systems
// and checks every solution value against a Q16.16 Thomas-algorithm predictor.
// Depends on tds_pkg, tds_if and the solver RTL.
`timescale 1ns / 1ps
module tridiagonal_system_solver_top_tb;
  import tds_pkg::*;

  localparam int MAX_ROWS = 64;
  localparam int FRAC = 16;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 300;

  logic clk;
  logic rst;

  tds_if #(.payload_t(row_t))  in_ch (clk);
  tds_if #(.payload_t(soln_t)) out_ch (clk);

  tridiagonal_system_solver_top #(
    .MAX_ROWS(MAX_ROWS), .DATA_WIDTH(32), .FRAC_BITS(FRAC)
  ) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  // Predictor state: forward-sweep pairs per row and running values
  longint ratio_mem [MAX_ROWS];
  longint offset_mem [MAX_ROWS];
  int     rows_seen;
  longint last_ratio;
  longint last_offset;
  bit     pivot_zero;

  soln_t  solution_q [$];
  int     fail_count;
  bit     idle_on;
  int     hold_request;
  int     hold_left;
  int     quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Exact product, magnitude shifted (truncation toward zero), saturated
  function automatic longint q_mul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = m >>> FRAC;
    return clamp_q((p < 0) ? -m : m);
  endfunction

  // Quotient (n << FRAC) / d toward zero; zero divisor saturates by sign
  function automatic longint q_div(longint n, longint d, ref bit sing);
    longint nm;
    longint dm;
    longint q;
    if (d == 0) begin
      sing = 1'b1;
      if (n > 0) return Q_MAX;
      if (n < 0) return Q_MIN;
      return 0;
    end
    nm = ((n < 0) ? -n : n) <<< FRAC;
    dm = (d < 0) ? -d : d;
    q = nm / dm;
    if ((n < 0) != (d < 0)) return (q > -Q_MIN) ? Q_MIN : -q;
    return (q > Q_MAX) ? Q_MAX : q;
  endfunction

  // Forward sweep on one row; on the final row queue the back-substituted unknowns
  function automatic void sweep_row(row_t r);
    int     k;
    longint a;
    longint den;
    longint num;
    longint x;
    bit     sing;
    bit     fin;
    soln_t  s;
    k = (rows_seen < MAX_ROWS) ? rows_seen : MAX_ROWS - 1;
    a = (k == 0) ? 0 : longint'(r.sub_diag);
    fin = r.last_row || (k >= MAX_ROWS - 1);
    den = clamp_q(q_mul(a, last_ratio) + longint'(r.main_diag));
    num = clamp_q(longint'(r.rhs) - q_mul(a, last_offset));
    sing = pivot_zero;
    if (!fin) begin
      ratio_mem[k] = q_div(clamp_q(-longint'(r.super_diag)), den, sing);
      offset_mem[k] = q_div(num, den, sing);
      last_ratio = ratio_mem[k];
      last_offset = offset_mem[k];
      pivot_zero = sing;
      rows_seen = k + 1;
      return;
    end
    x = q_div(num, den, sing);
    for (int i = k; i >= 0; i--) begin
      if (i < k) x = clamp_q(q_mul(ratio_mem[i], x) + offset_mem[i]);
      s.solution = x[31:0];
      s.row_index = i[ROW_W-1:0];
      s.last_result = (i == 0);
      s.singular = sing;
      solution_q.push_back(s);
    end
    rows_seen = 0;
    last_ratio = 0;
    last_offset = 0;
    pivot_zero = 1'b0;
  endfunction

  // Offer one row, with optional random gaps, and predict once accepted
  task automatic send_row(row_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    sweep_row(r);
  endtask

  task automatic send_system(int n, bit dominant);
    row_t r;
    for (int i = 0; i < n; i++) begin
      if (dominant) begin
        r.main_diag = $urandom_range(8 << FRAC, 16 << FRAC);
        if ($urandom_range(0, 1)) r.main_diag = -r.main_diag;
        r.sub_diag = $signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC);
        r.super_diag = $signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC);
        r.rhs = $signed($urandom_range(0, 200 << FRAC)) - (100 << FRAC);
      end else begin
        r.main_diag = $urandom();
        r.sub_diag = $urandom();
        r.super_diag = $urandom();
        r.rhs = $urandom();
      end
      r.last_row = (i == n - 1);
      send_row(r);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Extremes, one-row systems, zero pivots and ignored off-diagonal entries
  task automatic test_directed();
    row_t r;
    r = '{32'sd123, 32'sd2 << FRAC, 32'sd5, 32'sd7 << FRAC, 1'b1};
    send_row(r);
    r = '{32'sd0, 32'sd0, 32'sd0, 32'sd3 << FRAC, 1'b1};
    send_row(r);
    r = '{32'sd0, 32'sd0, 32'sd0, -(32'sd3 << FRAC), 1'b1};
    send_row(r);
    r = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1};
    send_row(r);
    r = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0};
    send_row(r);
    r = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b1};
    send_row(r);
    r = '{32'hffffffff, 32'sd1, 32'h80000000, 32'h7fffffff, 1'b1};
    send_row(r);
    // three rows, well conditioned, off-diagonal ends set to junk
    r = '{32'h5a5a5a5a, 32'sd4 << FRAC, 32'sd1 << FRAC, 32'sd5 << FRAC, 1'b0};
    send_row(r);
    r = '{32'sd1 << FRAC, 32'sd4 << FRAC, 32'sd1 << FRAC, 32'sd6 << FRAC, 1'b0};
    send_row(r);
    r = '{32'sd1 << FRAC, 32'sd4 << FRAC, 32'ha5a5a5a5, 32'sd5 << FRAC, 1'b1};
    send_row(r);
    // zero pivot part-way down
    r = '{32'sd0, 32'sd1 << FRAC, 32'sd1 << FRAC, 32'sd1 << FRAC, 1'b0};
    send_row(r);
    r = '{32'sd1 << FRAC, 32'sd1 << FRAC, 32'sd2 << FRAC, 32'sd2 << FRAC, 1'b0};
    send_row(r);
    r = '{32'sd1 << FRAC, 32'sd3 << FRAC, 32'sd0, 32'sd1 << FRAC, 1'b1};
    send_row(r);
    wait_drained();
  endtask

  // Last_row held low: row MAX_ROWS-1 must still close the system
  task automatic test_forced_last();
    row_t r;
    for (int i = 0; i < MAX_ROWS; i++) begin
      r.main_diag = (32'sd10 << FRAC) + $urandom_range(0, 1 << FRAC);
      r.sub_diag = $signed($urandom_range(0, 4 << FRAC)) - (2 << FRAC);
      r.super_diag = $signed($urandom_range(0, 4 << FRAC)) - (2 << FRAC);
      r.rhs = $signed($urandom_range(0, 40 << FRAC)) - (20 << FRAC);
      r.last_row = 1'b0;
      send_row(r);
    end
    send_system(1, 1'b1);
    wait_drained();
  endtask

  // Receiver holds off while rows keep coming, so the input stalls
  task automatic test_backpressure();
    hold_request = LONG_HOLD;
    send_system(3, 1'b1);
    send_system(4, 1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 12) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      send_system(n, $urandom_range(0, 4) != 0);
      sent += n;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    send_system(5, 1'b1);
    send_system(1, 1'b0);
    send_system(4, 1'b0);
    in_ch.valid <= 1'b0;
  endtask

  // Output ready: random bursts of stall plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted solution with the oldest prediction
  always @(posedge clk) begin
    soln_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (solution_q.size() == 0) begin
        $error("unexpected solution %0d row %0d", out_ch.data.solution,
               out_ch.data.row_index);
        fail_count++;
      end else begin
        e = solution_q.pop_front();
        if (out_ch.data.solution !== e.solution) begin
          $error("solution: expected %0d actual %0d", e.solution, out_ch.data.solution);
          fail_count++;
        end
        if (out_ch.data.row_index !== e.row_index) begin
          $error("row_index: expected %0d actual %0d", e.row_index, out_ch.data.row_index);
          fail_count++;
        end
        if (out_ch.data.last_result !== e.last_result) begin
          $error("last_result: expected %0b actual %0b", e.last_result,
                 out_ch.data.last_result);
          fail_count++;
        end
        if (out_ch.data.singular !== e.singular) begin
          $error("singular: expected %0b actual %0b", e.singular, out_ch.data.singular);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    idle_on = 1'b1;
    hold_request = 0;
    hold_left = 0;
    quiet_cycles = 0;
    rows_seen = 0;
    last_ratio = 0;
    last_offset = 0;
    pivot_zero = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_forced_last();
    test_backpressure();
    test_random();
    test_no_idle();

    while (solution_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
